// ===== hw/rtl/c8ie_pkg.sv =====
package c8ie_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int ROW_BYTES   = SCREEN_W / 8;
    localparam int FB_BYTES    = ROW_BYTES * SCREEN_H;
    localparam int FB_AW       = $clog2(FB_BYTES);
    localparam int FONT_BYTES  = 80;

    localparam logic [11:0] PC_START   = 12'h200;
    localparam logic [15:0] SEED_RESET = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [7:0]  RECIP_10   = 8'd205;

    // item functions
    localparam logic [1:0] FN_EXEC = 2'd0;
    localparam logic [1:0] FN_TICK = 2'd1;
    localparam logic [1:0] FN_MWR  = 2'd2;
    localparam logic [1:0] FN_FBRD = 2'd3;

    // opcode classes (top nibble)
    localparam logic [3:0] CL_SYS   = 4'h0;
    localparam logic [3:0] CL_JMP   = 4'h1;
    localparam logic [3:0] CL_CALL  = 4'h2;
    localparam logic [3:0] CL_SEQI  = 4'h3;
    localparam logic [3:0] CL_SNEI  = 4'h4;
    localparam logic [3:0] CL_SEQ   = 4'h5;
    localparam logic [3:0] CL_LDI   = 4'h6;
    localparam logic [3:0] CL_ADDI  = 4'h7;
    localparam logic [3:0] CL_ALU   = 4'h8;
    localparam logic [3:0] CL_SNE   = 4'h9;
    localparam logic [3:0] CL_LDIDX = 4'hA;
    localparam logic [3:0] CL_JMPV  = 4'hB;
    localparam logic [3:0] CL_RND   = 4'hC;
    localparam logic [3:0] CL_DRAW  = 4'hD;
    localparam logic [3:0] CL_KEY   = 4'hE;
    localparam logic [3:0] CL_MISC  = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_EQ = 8'h9E;
    localparam logic [7:0] KEY_NE = 8'hA1;

    localparam logic [7:0] F_GET_DT = 8'h07;
    localparam logic [7:0] F_SET_DT = 8'h15;
    localparam logic [7:0] F_ADD_I  = 8'h1E;
    localparam logic [7:0] F_FONT   = 8'h29;
    localparam logic [7:0] F_BCD    = 8'h33;
    localparam logic [7:0] F_STORE  = 8'h55;
    localparam logic [7:0] F_LOAD   = 8'h65;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h10, 8'h30, 8'h50, 8'h10, 8'h10,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h80,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'h60, 8'h90, 8'h90, 8'hF0, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] addr;
        logic [7:0]  data;
        logic        key_down;
        logic [3:0]  key_code;
    } t_item;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] opcode;
        logic [7:0]  read_data;
        logic        screen_changed;
    } t_result;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_TICK, S_MWR, S_FBRD, S_FBCAP,
        S_FETCH0, S_FETCH1, S_FETCH2, S_REGRD, S_EXEC,
        S_CLR, S_DR0, S_DR1, S_DR2, S_DR3,
        S_BCD0, S_BCD1, S_BCD2, S_ST0, S_ST1, S_LD0, S_LD1,
        S_IUPD, S_VF, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_INIT, C_IDLE, C_TICK, C_MWR, C_FBRD, C_FBCAP,
        C_FETCH0, C_FETCH1, C_FETCH2, C_REGRD, C_EXEC,
        C_CLR, C_DR0, C_DR1, C_DR2, C_DR3,
        C_BCD0, C_BCD1, C_BCD2, C_ST0, C_ST1, C_LD0, C_LD1,
        C_IUPD, C_VF, C_DONE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        logic    accept;
    } t_cmd;

    typedef struct packed {
        logic [15:0] op;
        logic        init_last;
        logic        clr_last;
        logic        cnt_eq_x;
        logic        cnt_eq_nm1;
    } t_stat;

    function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (a < MEM_AW'(FONT_BYTES))
            b = FONT[a[6:0]];
        return b;
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic [15:0] s;
        s = {1'b0, v[15:1]};
        if (v[0])
            s = s ^ LFSR_TAPS;
        return s;
    endfunction

endpackage

// ===== hw/rtl/c8ie_ctrl.sv =====
module c8ie_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_func,
    input  c8ie_pkg::t_stat   i_stat,
    output c8ie_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import c8ie_pkg::*;

    t_state r_state, n_state;
    logic [3:0] cls, nib;
    logic [7:0] nn;

    assign cls = i_stat.op[15:12];
    assign nib = i_stat.op[3:0];
    assign nn  = i_stat.op[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:   if (i_stat.init_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_func)
                        FN_EXEC: n_state = S_FETCH0;
                        FN_TICK: n_state = S_TICK;
                        FN_MWR:  n_state = S_MWR;
                        default: n_state = S_FBRD;
                    endcase
                end
            end
            S_TICK:   n_state = S_DONE;
            S_MWR:    n_state = S_DONE;
            S_FBRD:   n_state = S_FBCAP;
            S_FBCAP:  n_state = S_DONE;
            S_FETCH0: n_state = S_FETCH1;
            S_FETCH1: n_state = S_FETCH2;
            S_FETCH2: n_state = S_REGRD;
            S_REGRD:  n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_DONE;
                unique case (cls)
                    CL_SYS:  if (i_stat.op == OP_CLS) n_state = S_CLR;
                    CL_ALU: begin
                        unique case (nib) inside
                            ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: n_state = S_VF;
                            default: n_state = S_DONE;
                        endcase
                    end
                    CL_DRAW: n_state = (nib == 4'h0) ? S_VF : S_DR0;
                    CL_MISC: begin
                        unique case (nn)
                            F_ADD_I: n_state = S_VF;
                            F_BCD:   n_state = S_BCD0;
                            F_STORE: n_state = S_ST0;
                            F_LOAD:  n_state = S_LD0;
                            default: n_state = S_DONE;
                        endcase
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_CLR:    if (i_stat.clr_last) n_state = S_DONE;
            S_DR0:    n_state = S_DR1;
            S_DR1:    n_state = S_DR2;
            S_DR2:    n_state = S_DR3;
            S_DR3:    n_state = i_stat.cnt_eq_nm1 ? S_VF : S_DR0;
            S_BCD0:   n_state = S_BCD1;
            S_BCD1:   n_state = S_BCD2;
            S_BCD2:   n_state = S_DONE;
            S_ST0:    n_state = S_ST1;
            S_ST1:    n_state = i_stat.cnt_eq_x ? S_IUPD : S_ST0;
            S_LD0:    n_state = S_LD1;
            S_LD1:    n_state = i_stat.cnt_eq_x ? S_IUPD : S_LD0;
            S_IUPD:   n_state = S_DONE;
            S_VF:     n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept = 1'b0;
        o_busy       = 1'b1;
        unique case (r_state)
            S_INIT:   o_cmd.op = C_INIT;
            S_IDLE: begin
                o_cmd.op     = C_IDLE;
                o_cmd.accept = i_start;
                o_busy       = 1'b0;
            end
            S_TICK:   o_cmd.op = C_TICK;
            S_MWR:    o_cmd.op = C_MWR;
            S_FBRD:   o_cmd.op = C_FBRD;
            S_FBCAP:  o_cmd.op = C_FBCAP;
            S_FETCH0: o_cmd.op = C_FETCH0;
            S_FETCH1: o_cmd.op = C_FETCH1;
            S_FETCH2: o_cmd.op = C_FETCH2;
            S_REGRD:  o_cmd.op = C_REGRD;
            S_EXEC:   o_cmd.op = C_EXEC;
            S_CLR:    o_cmd.op = C_CLR;
            S_DR0:    o_cmd.op = C_DR0;
            S_DR1:    o_cmd.op = C_DR1;
            S_DR2:    o_cmd.op = C_DR2;
            S_DR3:    o_cmd.op = C_DR3;
            S_BCD0:   o_cmd.op = C_BCD0;
            S_BCD1:   o_cmd.op = C_BCD1;
            S_BCD2:   o_cmd.op = C_BCD2;
            S_ST0:    o_cmd.op = C_ST0;
            S_ST1:    o_cmd.op = C_ST1;
            S_LD0:    o_cmd.op = C_LD0;
            S_LD1:    o_cmd.op = C_LD1;
            S_IUPD:   o_cmd.op = C_IUPD;
            S_VF:     o_cmd.op = C_VF;
            S_DONE:   o_cmd.op = C_DONE;
            default:  o_cmd.op = C_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/c8ie_dp.sv =====
module c8ie_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  c8ie_pkg::t_cmd    i_cmd,
    input  c8ie_pkg::t_item   i_item,
    input  logic              i_cfg_valid,
    input  logic [15:0]       i_cfg_data,
    output c8ie_pkg::t_stat   o_stat,
    output logic              o_done,
    output c8ie_pkg::t_result o_result
);
    import c8ie_pkg::*;

    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_fb [FB_BYTES];
    logic [7:0]        r_vreg [16];
    logic [11:0]       r_stack [STACK_DEPTH];

    logic [7:0]        r_mem_q, r_fb_q, r_va, r_vb;
    logic [11:0]       r_pc;
    logic [15:0]       r_i, r_lfsr, r_op;
    logic [SP_W-1:0]   r_sp;
    logic [7:0]        r_delay;
    logic [MEM_AW-1:0] r_cnt;
    logic [1:0]        r_func;
    logic [11:0]       r_addr;
    logic [7:0]        r_data, r_line, r_rd;
    logic              r_kd, r_chg, r_flag, r_pend, r_strobe;
    logic [3:0]        r_kc;
    logic [1:0]        r_h;
    logic [6:0]        r_rem;
    t_result           r_result;

    logic [3:0]  cls, vx_idx, vy_idx, nib;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn, pc2, pc4, i_off, pc_nxt;
    logic        key_match, skip, clr_last;
    logic [SP_W-1:0] sp_inc, sp_dec;

    logic [MEM_AW-1:0] mem_addr;
    logic              mem_we;
    logic [7:0]        mem_wd;
    logic [FB_AW-1:0]  fb_ra, fb_wa, pos0, pos1;
    logic              fb_we;
    logic [7:0]        fb_wd;
    logic [3:0]        rf_ra, rf_rb, rf_wa;
    logic              rf_we;
    logic [7:0]        rf_wd;

    logic [4:0]  row_y;
    logic [15:0] spr;
    logic [8:0]  add9;
    logic [7:0]  alu_res;
    logic        alu_flag;
    logic [16:0] isum;
    logic [14:0] prod;
    logic [3:0]  tens, ones;
    logic [7:0]  bcd_sub;
    logic [15:0] lfsr_nxt;

    assign cls    = r_op[15:12];
    assign vx_idx = r_op[11:8];
    assign vy_idx = r_op[7:4];
    assign nib    = r_op[3:0];
    assign nn     = r_op[7:0];
    assign nnn    = r_op[11:0];
    assign vx     = r_va;
    assign vy     = r_vb;
    assign pc2    = r_pc + 12'd2;
    assign pc4    = r_pc + 12'd4;
    assign i_off  = r_i[11:0] + {8'h00, r_cnt[3:0]};
    assign key_match = r_kd && (vx == {4'h0, r_kc});
    assign clr_last  = (r_cnt == MEM_AW'(FB_BYTES));
    assign sp_inc = (r_sp == SP_W'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SP_W'(STACK_DEPTH - 1) : r_sp - 1'b1;
    assign lfsr_nxt = lfsr_step(r_lfsr);

    // sprite row position, wraps on both axes
    assign row_y = r_vb[4:0] + {1'b0, r_cnt[3:0]};
    assign pos0  = {row_y, r_va[5:3]};
    assign pos1  = {row_y, r_va[5:3] + 3'd1};
    assign spr   = {r_line, 8'h00} >> r_va[2:0];

    assign isum  = {1'b0, r_i} + {9'h000, vx};
    assign prod  = 15'(r_rem) * 15'(RECIP_10);
    assign tens  = prod[14:11];
    assign ones  = 4'(r_rem - 7'(tens) * 7'd10);
    assign bcd_sub = (vx >= 8'd200) ? vx - 8'd200 : ((vx >= 8'd100) ? vx - 8'd100 : vx);

    assign o_stat.op         = r_op;
    assign o_stat.init_last  = (r_cnt == MEM_AW'(MEM_BYTES - 1));
    assign o_stat.clr_last   = clr_last;
    assign o_stat.cnt_eq_x   = (r_cnt[3:0] == vx_idx);
    assign o_stat.cnt_eq_nm1 = (r_cnt[3:0] == nib - 4'd1);

    assign o_done   = r_strobe;
    assign o_result = r_result;

    always_comb begin
        add9 = {1'b0, vx} + {1'b0, vy};
        alu_res  = vx;
        alu_flag = 1'b0;
        case (nib)
            ALU_MOV:  alu_res = vy;
            ALU_OR:   alu_res = vx | vy;
            ALU_AND:  alu_res = vx & vy;
            ALU_XOR:  alu_res = vx ^ vy;
            ALU_ADD: begin
                alu_res  = add9[7:0];
                alu_flag = add9[8];
            end
            ALU_SUB: begin
                alu_res  = vx - vy;
                alu_flag = (vx >= vy);
            end
            ALU_SHR: begin
                alu_res  = {1'b0, vx[7:1]};
                alu_flag = vx[0];
            end
            ALU_SUBN: begin
                alu_res  = vy - vx;
                alu_flag = (vy >= vx);
            end
            ALU_SHL: begin
                alu_res  = {vx[6:0], 1'b0};
                alu_flag = vx[7];
            end
            default: alu_res = vx;
        endcase
    end

    always_comb begin
        case (cls)
            CL_SEQI: skip = (vx == nn);
            CL_SNEI: skip = (vx != nn);
            CL_SEQ:  skip = (vx == vy);
            CL_SNE:  skip = (vx != vy);
            CL_KEY:  skip = ((nn == KEY_EQ) && key_match) || ((nn == KEY_NE) && !key_match);
            default: skip = 1'b0;
        endcase
    end

    // program counter after the executed instruction
    always_comb begin
        pc_nxt = skip ? pc4 : pc2;
        case (cls)
            CL_SYS: begin
                if (r_op == OP_RET)
                    pc_nxt = r_stack[sp_dec] + 12'd2;
                else if (r_op != OP_CLS)
                    pc_nxt = nnn;
            end
            CL_JMP, CL_CALL: pc_nxt = nnn;
            CL_JMPV: pc_nxt = nnn + {4'h0, vy};
            default: pc_nxt = skip ? pc4 : pc2;
        endcase
    end

    // main memory port
    always_comb begin
        mem_addr = r_pc;
        mem_we   = 1'b0;
        mem_wd   = r_va;
        case (i_cmd.op)
            C_INIT: begin
                mem_addr = r_cnt;
                mem_we   = 1'b1;
                mem_wd   = font_byte(r_cnt);
            end
            C_MWR: begin
                mem_addr = r_addr;
                mem_we   = 1'b1;
                mem_wd   = r_data;
            end
            C_FETCH1: mem_addr = r_pc + 12'd1;
            C_DR0:    mem_addr = i_off;
            C_LD0:    mem_addr = i_off;
            C_ST1: begin
                mem_addr = i_off;
                mem_we   = 1'b1;
            end
            C_BCD0: begin
                mem_addr = r_i[11:0];
                mem_we   = 1'b1;
                mem_wd   = {6'h00, r_h};
            end
            C_BCD1: begin
                mem_addr = r_i[11:0] + 12'd1;
                mem_we   = 1'b1;
                mem_wd   = {4'h0, tens};
            end
            C_BCD2: begin
                mem_addr = r_i[11:0] + 12'd2;
                mem_we   = 1'b1;
                mem_wd   = {4'h0, ones};
            end
            default: mem_addr = r_pc;
        endcase
    end

    // framebuffer port, read and write addresses differ during a draw
    always_comb begin
        fb_ra = r_addr[FB_AW-1:0];
        fb_wa = r_cnt[FB_AW-1:0];
        fb_we = 1'b0;
        fb_wd = 8'h00;
        case (i_cmd.op)
            C_INIT: fb_we = 1'b1;
            C_CLR: begin
                fb_ra = r_cnt[FB_AW-1:0];
                fb_we = !clr_last;
            end
            C_DR1: fb_ra = pos0;
            C_DR2: begin
                fb_ra = pos1;
                fb_wa = pos0;
                fb_we = 1'b1;
                fb_wd = r_fb_q ^ spr[15:8];
            end
            C_DR3: begin
                fb_wa = pos1;
                fb_we = 1'b1;
                fb_wd = r_fb_q ^ spr[7:0];
            end
            default: fb_we = 1'b0;
        endcase
    end

    // register file port
    always_comb begin
        rf_ra = (i_cmd.op == C_ST0) ? r_cnt[3:0] : vx_idx;
        rf_rb = (cls == CL_JMPV) ? 4'h0 : vy_idx;
        rf_wa = vx_idx;
        rf_we = 1'b0;
        rf_wd = alu_res;
        case (i_cmd.op)
            C_EXEC: begin
                case (cls)
                    CL_LDI: begin
                        rf_we = 1'b1;
                        rf_wd = nn;
                    end
                    CL_ADDI: begin
                        rf_we = 1'b1;
                        rf_wd = vx + nn;
                    end
                    CL_ALU: begin
                        case (nib) inside
                            ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                            ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: rf_we = 1'b1;
                            default: rf_we = 1'b0;
                        endcase
                    end
                    CL_RND: begin
                        rf_we = 1'b1;
                        rf_wd = lfsr_nxt[7:0] & nn;
                    end
                    CL_MISC: begin
                        rf_we = (nn == F_GET_DT);
                        rf_wd = r_delay;
                    end
                    default: rf_we = 1'b0;
                endcase
            end
            C_LD1: begin
                rf_wa = r_cnt[3:0];
                rf_we = 1'b1;
                rf_wd = r_mem_q;
            end
            C_VF: begin
                rf_wa = 4'hF;
                rf_we = 1'b1;
                rf_wd = {7'h00, r_flag};
            end
            default: rf_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_mem[mem_addr];
        if (mem_we)
            r_mem[mem_addr] <= mem_wd;
    end

    always_ff @(posedge i_clk) begin
        r_fb_q <= r_fb[fb_ra];
        if (fb_we)
            r_fb[fb_wa] <= fb_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++)
                r_vreg[k] <= 8'h00;
        end else if (rf_we) begin
            r_vreg[rf_wa] <= rf_wd;
        end
        r_va <= r_vreg[rf_ra];
        r_vb <= r_vreg[rf_rb];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == C_EXEC && cls == CL_CALL)
            r_stack[r_sp] <= r_pc;
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= PC_START;
            r_i      <= 16'h0000;
            r_sp     <= '0;
            r_delay  <= 8'h00;
            r_lfsr   <= SEED_RESET;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == C_DONE);
            r_pend   <= (i_cmd.op == C_CLR) && !clr_last;
            if (i_cfg_valid)
                r_lfsr <= (i_cfg_data == 16'h0000) ? 16'h0001 : i_cfg_data;
            else if (i_cmd.op == C_EXEC && cls == CL_RND)
                r_lfsr <= lfsr_nxt;
            case (i_cmd.op)
                C_IDLE: if (i_cmd.accept) r_cnt <= '0;
                C_INIT, C_CLR, C_DR3, C_ST1, C_LD1: r_cnt <= r_cnt + 1'b1;
                C_TICK: if (r_delay != 8'h00) r_delay <= r_delay - 8'd1;
                C_IUPD: r_i <= r_i + {12'h000, vx_idx} + 16'd1;
                C_EXEC: begin
                    r_pc <= pc_nxt;
                    case (cls)
                        CL_SYS:   if (r_op == OP_RET) r_sp <= sp_dec;
                        CL_CALL:  r_sp <= sp_inc;
                        CL_LDIDX: r_i <= {4'h0, nnn};
                        CL_MISC: begin
                            case (nn)
                                F_SET_DT: r_delay <= vx;
                                F_ADD_I:  r_i <= isum[15:0];
                                F_FONT:   r_i <= {6'h00, vx, 2'b00} + {8'h00, vx};
                                default:  r_i <= r_i;
                            endcase
                        end
                        default: r_sp <= r_sp;
                    endcase
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // per-item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_item.func;
            r_addr <= i_item.addr;
            r_data <= i_item.data;
            r_kd   <= i_item.key_down;
            r_kc   <= i_item.key_code;
            r_op   <= 16'h0000;
            r_rd   <= 8'h00;
            r_chg  <= 1'b0;
        end
        case (i_cmd.op)
            C_FETCH1: r_op[15:8] <= r_mem_q;
            C_FETCH2: r_op[7:0]  <= r_mem_q;
            C_FBCAP:  r_rd <= r_fb_q;
            C_EXEC: begin
                r_flag <= (cls == CL_DRAW) ? 1'b0
                        : ((cls == CL_MISC) ? (isum > 17'h00FFF) : alu_flag);
                r_h   <= (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
                r_rem <= bcd_sub[6:0];
            end
            C_CLR: if (r_pend && r_fb_q != 8'h00) r_chg <= 1'b1;
            C_DR1: begin
                r_line <= r_mem_q;
                if (r_mem_q != 8'h00) r_chg <= 1'b1;
            end
            C_DR2: if ((r_fb_q & spr[15:8]) != 8'h00) r_flag <= 1'b1;
            C_DR3: if ((r_fb_q & spr[7:0]) != 8'h00) r_flag <= 1'b1;
            C_DONE: begin
                r_result.pc             <= r_pc;
                r_result.opcode         <= (r_func == FN_EXEC) ? r_op : 16'h0000;
                r_result.read_data      <= r_rd;
                r_result.screen_changed <= r_chg;
            end
            default: r_line <= r_line;
        endcase
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held longer than one cycle");

    a_done_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == C_DONE) |=> r_strobe)
        else $error("finished item produced no result strobe");

    a_vf_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == C_VF) |-> (cls == CL_ALU || cls == CL_DRAW || cls == CL_MISC))
        else $error("flag write from an opcode that sets no flag");

    a_clr_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == C_CLR && !clr_last) |=> (r_pend && r_cnt != '0))
        else $error("clear sweep lost a read");

endmodule

// ===== hw/rtl/chip8_instruction_engine.sv =====
// chip-8 style instruction engine
// input channel: present an item on i_item with start high; it is taken at a clock edge
// where busy is low. func picks execute, delay tick, memory write or framebuffer read.
// result channel: o_done is high for exactly one cycle with o_result; the receiver cannot
// stall, so every result must be taken in that cycle. busy stays high until the result shows.
// config channel: i_cfg_valid/o_cfg_ready/i_cfg_data load the lfsr seed; ready is always high.
// steps from accept to o_done: tick or memory write, then done; framebuffer read and
// capture; plain instruction: fetch of two bytes, register read, execute, result;
// flag-setting ops add a flag write, bcd three digit writes, store and load a read and
// a write per register and an index update, sprite draw a row read and two byte updates
// per row and a flag write, clear a framebuffer sweep. main memory has a single port.
// one item is in flight at a time; the next may be accepted in the cycle o_done is high.
// reset: synchronous, active low; afterwards a sweep over main memory loads the font, zeroes
// main memory and the framebuffer, with busy high throughout.
module chip8_instruction_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  c8ie_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_done,
    output c8ie_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data
);
    import c8ie_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    c8ie_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    c8ie_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

// ===== tb/sv/tb_chip8_instruction_engine.sv =====
`timescale 1ns / 100ps

module tb_chip8_instruction_engine;
    import c8ie_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   i_item = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    chip8_instruction_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // machine image kept by the testbench
    logic [7:0]  mem_img [MEM_BYTES];
    logic [7:0]  v_img [16];
    logic [15:0] idx_img;
    logic [11:0] pc_img;
    logic [11:0] stack_img [STACK_DEPTH];
    bit          stack_set [STACK_DEPTH];
    logic [3:0]  sp_img;
    logic [7:0]  delay_img;
    logic [7:0]  fb_img [FB_BYTES];
    logic [15:0] lfsr_img;

    t_result pending_results [$];
    int      mismatches = 0;
    int      cycle_cnt = 0;
    bit      no_idle = 1'b0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // compare every result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.pc !== want.pc || o_result.opcode !== want.opcode ||
                    o_result.read_data !== want.read_data ||
                    o_result.screen_changed !== want.screen_changed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: pc %h/%h op %h/%h rd %h/%h chg %b/%b",
                                 want.pc, o_result.pc, want.opcode, o_result.opcode,
                                 want.read_data, o_result.read_data,
                                 want.screen_changed, o_result.screen_changed);
                end
            end
        end
    end

    task automatic reset_image();
        for (int i = 0; i < MEM_BYTES; i++) mem_img[i] = '0;
        for (int i = 0; i < FONT_BYTES; i++) mem_img[i] = FONT[i];
        for (int i = 0; i < 16; i++) v_img[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++) stack_set[i] = 1'b0;
        for (int i = 0; i < FB_BYTES; i++) fb_img[i] = '0;
        idx_img = '0;
        pc_img = PC_START;
        sp_img = '0;
        delay_img = '0;
        lfsr_img = SEED_RESET;
    endtask

    function automatic logic [12:0] skip_if(input logic [11:0] nxt, input logic cond);
        return cond ? 13'(nxt + 12'd2) : 13'(nxt);
    endfunction

    // executes one instruction on the image, returns the screen-changed flag
    function automatic logic run_instr(input logic [15:0] op, input logic kd,
                                       input logic [3:0] kc);
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, line, mask;
        logic [11:0] nnn, nxt;
        logic [8:0]  s9;
        logic [16:0] s17;
        logic        hit, chg, km, flag;
        int          xx, yy, pos;
        x = op[11:8]; y = op[7:4]; n = op[3:0];
        nn = op[7:0]; nnn = op[11:0];
        vx = v_img[x]; vy = v_img[y];
        nxt = pc_img + 12'd2;
        hit = 1'b0; chg = 1'b0;
        km = kd && (vx == {4'b0, kc});
        case (op[15:12])
            CL_SYS: begin
                if (op == OP_CLS) begin
                    for (int i = 0; i < FB_BYTES; i++) begin
                        if (fb_img[i] != 0) chg = 1'b1;
                        fb_img[i] = '0;
                    end
                end else if (op == OP_RET) begin
                    sp_img = sp_img - 4'd1;
                    nxt = stack_img[sp_img] + 12'd2;
                end else begin
                    nxt = nnn;
                end
            end
            CL_JMP: nxt = nnn;
            CL_CALL: begin
                stack_img[sp_img] = pc_img;
                stack_set[sp_img] = 1'b1;
                sp_img = sp_img + 4'd1;
                nxt = nnn;
            end
            CL_SEQI: nxt = 12'(skip_if(nxt, vx == nn));
            CL_SNEI: nxt = 12'(skip_if(nxt, vx != nn));
            CL_SEQ:  nxt = 12'(skip_if(nxt, vx == vy));
            CL_LDI:  v_img[x] = nn;
            CL_ADDI: v_img[x] = vx + nn;
            CL_ALU: begin
                case (n)
                    ALU_MOV: v_img[x] = vy;
                    ALU_OR:  v_img[x] = vx | vy;
                    ALU_AND: v_img[x] = vx & vy;
                    ALU_XOR: v_img[x] = vx ^ vy;
                    ALU_ADD: begin
                        s9 = {1'b0, vx} + {1'b0, vy};
                        v_img[x] = s9[7:0];
                        v_img[15] = {7'b0, s9[8]};
                    end
                    ALU_SUB: begin
                        flag = vx >= vy;
                        v_img[x] = vx - vy;
                        v_img[15] = {7'b0, flag};
                    end
                    ALU_SHR: begin
                        v_img[x] = vx >> 1;
                        v_img[15] = {7'b0, vx[0]};
                    end
                    ALU_SUBN: begin
                        flag = vy >= vx;
                        v_img[x] = vy - vx;
                        v_img[15] = {7'b0, flag};
                    end
                    ALU_SHL: begin
                        v_img[x] = vx << 1;
                        v_img[15] = {7'b0, vx[7]};
                    end
                    default: ;
                endcase
            end
            CL_SNE:   nxt = 12'(skip_if(nxt, vx != vy));
            CL_LDIDX: idx_img = {4'b0, nnn};
            CL_JMPV:  nxt = nnn + {4'b0, v_img[0]};
            CL_RND: begin
                lfsr_img = lfsr_img[0] ? ({1'b0, lfsr_img[15:1]} ^ 16'hB400)
                                       : {1'b0, lfsr_img[15:1]};
                v_img[x] = lfsr_img[7:0] & nn;
            end
            CL_DRAW: begin
                for (int i = 0; i < n; i++) begin
                    line = mem_img[12'(idx_img + 16'(i))];
                    if (line != 0) chg = 1'b1;
                    yy = (vy % SCREEN_H + i) % SCREEN_H;
                    for (int b = 0; b < 8; b++) begin
                        if (line[7 - b]) begin
                            xx = (vx % SCREEN_W + b) % SCREEN_W;
                            pos = yy * ROW_BYTES + xx / 8;
                            mask = 8'h80 >> (xx % 8);
                            if ((fb_img[pos] & mask) != 0) hit = 1'b1;
                            fb_img[pos] = fb_img[pos] ^ mask;
                        end
                    end
                end
                v_img[15] = {7'b0, hit};
            end
            CL_KEY: begin
                if (nn == KEY_EQ && km) nxt = nxt + 12'd2;
                if (nn == KEY_NE && !km) nxt = nxt + 12'd2;
            end
            default: begin
                case (nn)
                    F_GET_DT: v_img[x] = delay_img;
                    F_SET_DT: delay_img = vx;
                    F_ADD_I: begin
                        s17 = {1'b0, idx_img} + 17'(vx);
                        idx_img = s17[15:0];
                        v_img[15] = {7'b0, s17 > 17'hFFF};
                    end
                    F_FONT: idx_img = 16'(vx) * 16'd5;
                    F_BCD: begin
                        mem_img[12'(idx_img)] = 8'(vx / 100);
                        mem_img[12'(idx_img + 16'd1)] = 8'((vx % 100) / 10);
                        mem_img[12'(idx_img + 16'd2)] = 8'(vx % 10);
                    end
                    F_STORE: begin
                        for (int i = 0; i <= x; i++) mem_img[12'(idx_img + 16'(i))] = v_img[i];
                        idx_img = idx_img + 16'(x) + 16'd1;
                    end
                    F_LOAD: begin
                        for (int i = 0; i <= x; i++) v_img[i] = mem_img[12'(idx_img + 16'(i))];
                        idx_img = idx_img + 16'(x) + 16'd1;
                    end
                    default: ;
                endcase
            end
        endcase
        pc_img = nxt;
        return chg;
    endfunction

    task automatic emulate_item(input t_item it);
        t_result r;
        logic [15:0] op;
        r = '0;
        case (it.func)
            FN_EXEC: begin
                op = {mem_img[pc_img], mem_img[pc_img + 12'd1]};
                r.opcode = op;
                r.screen_changed = run_instr(op, it.key_down, it.key_code);
            end
            FN_TICK: if (delay_img != 0) delay_img = delay_img - 8'd1;
            FN_MWR:  mem_img[it.addr] = it.data;
            default: r.read_data = fb_img[it.addr[7:0]];
        endcase
        r.pc = pc_img;
        pending_results.push_back(r);
    endtask

    // start idles at random in about a quarter of the cycles while the beat waits, unless no_idle is set
    task automatic send_item(input t_item it);
        bit go;
        i_item <= it;
        forever begin
            go = no_idle || ($urandom_range(99) >= 25);
            start <= go;
            @(posedge i_clk);
            if (go && !busy) break;
        end
        emulate_item(it);
    endtask

    task automatic send_simple(input logic [1:0] fn, input logic [11:0] a,
                               input logic [7:0] d);
        t_item it;
        it.func = fn; it.addr = a; it.data = d;
        it.key_down = 1'($urandom_range(1)); it.key_code = 4'($urandom_range(15));
        send_item(it);
    endtask

    task automatic exec_here(input logic kd, input logic [3:0] kc);
        t_item it;
        it.func = FN_EXEC; it.addr = 12'($urandom_range(4095));
        it.data = 8'($urandom_range(255));
        it.key_down = kd; it.key_code = kc;
        send_item(it);
    endtask

    // place one instruction at the current pc, then execute it
    task automatic run_op(input logic [15:0] op, input logic kd, input logic [3:0] kc);
        send_simple(FN_MWR, pc_img, op[15:8]);
        send_simple(FN_MWR, pc_img + 12'd1, op[7:0]);
        exec_here(kd, kc);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [15:0] seed);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lfsr_img = (seed == 0) ? 16'd1 : seed;
    endtask

    function automatic bit ret_ok();
        return stack_set[sp_img - 4'd1];
    endfunction

    function automatic logic [15:0] pick_op();
        logic [3:0]  cls, x, y;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [15:0] op;
        logic [7:0]  fsel [10];
        logic [3:0]  asel [9];
        fsel = '{F_GET_DT, F_SET_DT, F_ADD_I, F_FONT, F_BCD, F_STORE, F_LOAD,
                 8'h0A, 8'h18, 8'h00};
        asel = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                 ALU_SUBN, ALU_SHL};
        cls = 4'($urandom_range(15));
        x = 4'($urandom_range(15)); y = 4'($urandom_range(15));
        nn = 8'($urandom_range(255)); nnn = 12'($urandom_range(4095));
        op = {cls, nnn};
        case (cls)
            CL_SYS: begin
                case ($urandom_range(3))
                    0: op = OP_CLS;
                    1: op = ret_ok() ? OP_RET : {CL_SYS, nnn};
                    default: op = {CL_SYS, nnn};
                endcase
                if (op == OP_RET && !ret_ok()) op = 16'h00EF;
            end
            CL_SEQI, CL_SNEI: if ($urandom_range(1)) op = {cls, x, v_img[x]};
            CL_SEQ, CL_SNE: begin
                if ($urandom_range(2) == 0) y = x;
                op = {cls, x, y, 4'h0};
            end
            CL_ALU: op = {cls, x, y, ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                             : asel[$urandom_range(8)]};
            CL_DRAW: op = {cls, x, y, ($urandom_range(7) == 0) ? 4'hF
                                                              : 4'($urandom_range(15))};
            CL_KEY: op = {cls, x, ($urandom_range(5) == 0) ? nn
                                 : ($urandom_range(1) ? KEY_EQ : KEY_NE)};
            CL_MISC: op = {cls, x, ($urandom_range(9) == 0) ? nn : fsel[$urandom_range(8)]};
            default: ;
        endcase
        return op;
    endfunction

    task automatic random_step();
        int r;
        logic [15:0] op;
        logic [3:0] kc;
        r = $urandom_range(99);
        op = pick_op();
        kc = $urandom_range(1) ? v_img[op[11:8]][3:0] : 4'($urandom_range(15));
        if (r < 72) begin
            run_op(op, $urandom_range(3) != 0, kc);
        end else if (r < 80) begin
            // run whatever already sits at pc unless it would pop an unused stack slot
            if ({mem_img[pc_img], mem_img[pc_img + 12'd1]} == OP_RET && !ret_ok())
                run_op(op, 1'b1, kc);
            else
                exec_here(1'($urandom_range(1)), kc);
        end else if (r < 87) begin
            send_simple(FN_TICK, 12'($urandom_range(4095)), 8'($urandom_range(255)));
        end else if (r < 94) begin
            send_simple(FN_FBRD, 12'($urandom_range(4095)), 8'($urandom_range(255)));
        end else begin
            send_simple(FN_MWR, 12'($urandom_range(4095)), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_plain_funcs();
        send_simple(FN_TICK, 12'h000, 8'h00);
        send_simple(FN_FBRD, 12'hFFF, 8'hFF);
        send_simple(FN_MWR, 12'hFFF, 8'hFF);
        send_simple(FN_MWR, 12'h000, 8'h00);
    endtask

    task automatic test_alu_flags();
        run_op(16'h60FF, 1'b0, 4'h0);
        run_op(16'h6101, 1'b0, 4'h0);
        run_op({CL_ALU, 4'h0, 4'h1, ALU_ADD}, 1'b0, 4'h0);
        run_op({CL_ALU, 4'h0, 4'h1, ALU_SUB}, 1'b0, 4'h0);
        run_op({CL_ALU, 4'h1, 4'h0, ALU_SHL}, 1'b0, 4'h0);
        run_op({CL_ALU, 4'hF, 4'h1, ALU_SUBN}, 1'b0, 4'h0);
        run_op(16'h6F81, 1'b0, 4'h0);
        run_op({CL_ALU, 4'hF, 4'h0, ALU_SHR}, 1'b0, 4'h0);
    endtask

    task automatic test_draw_and_clear();
        run_op(16'h603F, 1'b0, 4'h0);
        run_op(16'h611F, 1'b0, 4'h0);
        run_op({CL_MISC, 4'h0, F_FONT}, 1'b0, 4'h0);
        run_op(16'hD01F, 1'b0, 4'h0);
        run_op(16'hD01F, 1'b0, 4'h0);
        run_op(16'hD015, 1'b0, 4'h0);
        run_op(16'hD010, 1'b0, 4'h0);
        send_simple(FN_FBRD, 12'hEF8, 8'h00);
        run_op(OP_CLS, 1'b0, 4'h0);
        run_op(OP_CLS, 1'b0, 4'h0);
    endtask

    task automatic test_flow_and_memory();
        run_op(16'h1FFE, 1'b0, 4'h0);
        run_op(16'h2400, 1'b0, 4'h0);
        run_op(OP_RET, 1'b0, 4'h0);
        run_op(16'h60FF, 1'b0, 4'h0);
        run_op(16'hBFFF, 1'b0, 4'h0);
        run_op(16'hAFFE, 1'b0, 4'h0);
        run_op({CL_MISC, 4'h0, F_BCD}, 1'b0, 4'h0);
        run_op({CL_MISC, 4'hF, F_STORE}, 1'b0, 4'h0);
        run_op({CL_MISC, 4'hF, F_LOAD}, 1'b0, 4'h0);
        run_op({CL_MISC, 4'h0, F_ADD_I}, 1'b0, 4'h0);
        run_op({CL_MISC, 4'h0, F_SET_DT}, 1'b0, 4'h0);
        send_simple(FN_TICK, 12'h000, 8'h00);
        run_op({CL_MISC, 4'h2, F_GET_DT}, 1'b0, 4'h0);
        run_op(16'h620F, 1'b0, 4'h0);
        run_op({CL_KEY, 4'h2, KEY_EQ}, 1'b1, 4'hF);
        run_op({CL_KEY, 4'h2, KEY_NE}, 1'b1, 4'hF);
        run_op({CL_KEY, 4'h2, KEY_NE}, 1'b0, 4'hF);
        run_op(16'hF00A, 1'b0, 4'h0);
        run_op(16'hF018, 1'b0, 4'h0);
        run_op(16'h3F00, 1'b0, 4'h0);
        run_op(16'h5230, 1'b0, 4'h0);
    endtask

    task automatic test_seeds();
        logic [15:0] seeds [4];
        seeds = '{16'h0000, 16'hFFFF, 16'h0001, 16'($urandom_range(65535))};
        run_op(16'hC0FF, 1'b0, 4'h0);
        foreach (seeds[k]) begin
            drain();
            write_seed(seeds[k]);
            run_op(16'hC1FF, 1'b0, 4'h0);
            run_op(16'hC20F, 1'b0, 4'h0);
        end
    endtask

    task automatic test_random(input int steps);
        for (int p = 0; p < 3; p++) begin
            drain();
            write_seed(p == 0 ? 16'hFFFF : 16'($urandom_range(65535)));
            for (int s = 0; s < steps; s++) begin
                no_idle = (p == 1) && (s < steps / 2);
                random_step();
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        reset_image();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_funcs();
        test_alu_flags();
        test_draw_and_clear();
        test_flow_and_memory();
        test_seeds();
        test_random(150);
        drain();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/c8ie_pkg.sv
hw/rtl/c8ie_ctrl.sv
hw/rtl/c8ie_dp.sv
hw/rtl/chip8_instruction_engine.sv
tb/sv/tb_chip8_instruction_engine.sv
